### sv/afc_pkg.sv
// afc_pkg: shared widths, register codes and types for the box/frustum classifier
// no dependencies; used by every module of the block

package afc_pkg;

    // field widths
    localparam int COORD_W    = 16;
    localparam int TAG_W      = 16;
    localparam int COEF_W     = 16;
    localparam int MARGIN_W   = 16;
    localparam int CFG_DATA_W = 4 * COEF_W;
    localparam int CFG_IDX_W  = 3;

    // plane count and pipeline depth
    localparam int NUM_PLANES = 6;
    localparam int PIPE_DEPTH = 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    // pipeline stage numbers
    localparam int ST_PREP = 0;
    localparam int ST_PROD = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_OUT  = 3;

    // internal arithmetic widths
    localparam int SUM_W   = COORD_W + 1;          // doubled center / extent
    localparam int PROD_W  = COEF_W + SUM_W + 2;   // |a| takes two extra bits
    localparam int DIST_W  = PROD_W + 2;           // four-term sum
    localparam int CMP_W   = DIST_W + 2;           // sum plus or minus margin
    localparam int D_SHIFT = 15;                   // d from 4 to 19 fraction bits

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MARGIN  = 3'd6;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd2621;

    typedef logic [CFG_DATA_W-1:0] plane_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } vec_t;

    // load strobes for the two plane stages
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } plane_ctl_t;

    // sign-extend a coordinate by one bit
    function automatic logic [SUM_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
        sext_coord = {v[COORD_W-1], v};
    endfunction

endpackage

### sv/afc_prep.sv
// afc_prep: first stage, doubled center and doubled extent of the box
// depends on afc_pkg

module afc_prep (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [afc_pkg::COORD_W-1:0] min_x,
    input  logic [afc_pkg::COORD_W-1:0] min_y,
    input  logic [afc_pkg::COORD_W-1:0] min_z,
    input  logic [afc_pkg::COORD_W-1:0] max_x,
    input  logic [afc_pkg::COORD_W-1:0] max_y,
    input  logic [afc_pkg::COORD_W-1:0] max_z,
    output afc_pkg::vec_t               cen,
    output afc_pkg::vec_t               ext
);

    afc_pkg::vec_t cen_reg;
    afc_pkg::vec_t ext_reg;

    // center = min + max, extent = max - min, both at 5 fraction bits
    always_ff @(posedge aclk) begin
        if (load) begin
            cen_reg.x <= afc_pkg::sext_coord(min_x) + afc_pkg::sext_coord(max_x);
            cen_reg.y <= afc_pkg::sext_coord(min_y) + afc_pkg::sext_coord(max_y);
            cen_reg.z <= afc_pkg::sext_coord(min_z) + afc_pkg::sext_coord(max_z);
            ext_reg.x <= afc_pkg::sext_coord(max_x) - afc_pkg::sext_coord(min_x);
            ext_reg.y <= afc_pkg::sext_coord(max_y) - afc_pkg::sext_coord(min_y);
            ext_reg.z <= afc_pkg::sext_coord(max_z) - afc_pkg::sext_coord(min_z);
        end
    end

    assign cen = cen_reg;
    assign ext = ext_reg;

endmodule

### sv/afc_plane.sv
// afc_plane: one plane, products in one stage and distance/radius sums in the next
// depends on afc_pkg

module afc_plane (
    input  logic                aclk,
    input  afc_pkg::plane_ctl_t ctl,
    input  afc_pkg::plane_t     plane,
    input  afc_pkg::vec_t       cen,
    input  afc_pkg::vec_t       ext,
    output afc_pkg::dist_t      pdist,
    output afc_pkg::dist_t      rad
);

    localparam int CW = afc_pkg::COEF_W;
    localparam int PW = afc_pkg::PROD_W;
    localparam int DW = afc_pkg::DIST_W;

    logic signed [CW-1:0] ca, cb, cc, cd;
    logic signed [CW+1:0] wa, wb, wc;
    logic signed [CW+1:0] abs_a, abs_b, abs_c;

    logic signed [PW-1:0] pa_next, pb_next, pc_next;
    logic signed [PW-1:0] ra_next, rb_next, rc_next;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [PW-1:0] ra_reg, rb_reg, rc_reg;

    logic signed [DW-1:0] dist19, rad19;
    afc_pkg::dist_t       dist_reg, rad_reg;

    // unpack coefficients
    assign ca = plane[CW-1:0];
    assign cb = plane[2*CW-1:CW];
    assign cc = plane[3*CW-1:2*CW];
    assign cd = plane[4*CW-1:3*CW];

    // absolute values, wide enough for the most negative code
    assign wa    = {{2{ca[CW-1]}}, ca};
    assign wb    = {{2{cb[CW-1]}}, cb};
    assign wc    = {{2{cc[CW-1]}}, cc};
    assign abs_a = ca[CW-1] ? -wa : wa;
    assign abs_b = cb[CW-1] ? -wb : wb;
    assign abs_c = cc[CW-1] ? -wc : wc;

    // per-axis products
    assign pa_next = PW'(ca) * PW'($signed(cen.x));
    assign pb_next = PW'(cb) * PW'($signed(cen.y));
    assign pc_next = PW'(cc) * PW'($signed(cen.z));
    assign ra_next = PW'(abs_a) * PW'($signed(ext.x));
    assign rb_next = PW'(abs_b) * PW'($signed(ext.y));
    assign rc_next = PW'(abs_c) * PW'($signed(ext.z));

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
            rc_reg <= rc_next;
        end
    end

    // sums at 19 fraction bits, floored to 18
    assign dist19 = DW'(pa_reg) + DW'(pb_reg) + DW'(pc_reg) + (DW'(cd) <<< afc_pkg::D_SHIFT);
    assign rad19  = DW'(ra_reg) + DW'(rb_reg) + DW'(rc_reg);

    always_ff @(posedge aclk) begin
        if (ctl.load_sum) begin
            dist_reg <= dist19 >>> 1;
            rad_reg  <= rad19 >>> 1;
        end
    end

    assign pdist = dist_reg;
    assign rad   = rad_reg;

endmodule

### sv/afc_decide.sv
// afc_decide: last stage, margin tests against all planes and the two flags
// depends on afc_pkg

module afc_decide (
    input  logic                         aclk,
    input  logic                         load,
    input  afc_pkg::dist_t               pdist [afc_pkg::NUM_PLANES],
    input  afc_pkg::dist_t               rad   [afc_pkg::NUM_PLANES],
    input  logic [afc_pkg::MARGIN_W-1:0] margin,
    output logic                         visible,
    output logic                         fully_inside
);

    localparam int MW = afc_pkg::CMP_W;

    logic signed [MW-1:0]             margin_ext;
    logic [afc_pkg::NUM_PLANES-1:0]   beyond;
    logic [afc_pkg::NUM_PLANES-1:0]   clear;
    logic                             visible_reg, inside_reg;

    assign margin_ext = $signed(MW'(margin));

    // beyond: dist + rad < -margin; clear: dist - rad >= margin
    always_comb begin
        logic signed [MW-1:0] lo;
        logic signed [MW-1:0] hi;
        for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
            lo        = MW'(pdist[i]) + MW'(rad[i]) + margin_ext;
            hi        = MW'(pdist[i]) - MW'(rad[i]) - margin_ext;
            beyond[i] = lo[MW-1];
            clear[i]  = !hi[MW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            visible_reg <= ~|beyond;
            inside_reg  <= &clear;
        end
    end

    assign visible      = visible_reg;
    assign fully_inside = inside_reg;

endmodule

### sv/aabb_frustum_classify.sv
// aabb_frustum_classify: top level, configuration registers, pipeline control
// depends on afc_pkg, afc_prep, afc_plane, afc_decide

// Classifies one axis-aligned box per cycle against six planes. The path is a
// four-stage pipeline: box center and extent, the 36 per-plane products, the
// distance and radius sums, then the margin compares. Throughput is one box
// per cycle while m_ready stays high. Each stage holds its item when the stage
// after it is full and stalled, so s_ready is low only when all four stages
// hold items and m_ready is low. Planes and margin are written through the cfg
// port, which is always ready, and must only change while no box is in flight.

module aabb_frustum_classify (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [afc_pkg::TAG_W-1:0]     s_object_tag,
    input  logic [afc_pkg::COORD_W-1:0]   s_min_x,
    input  logic [afc_pkg::COORD_W-1:0]   s_min_y,
    input  logic [afc_pkg::COORD_W-1:0]   s_min_z,
    input  logic [afc_pkg::COORD_W-1:0]   s_max_x,
    input  logic [afc_pkg::COORD_W-1:0]   s_max_y,
    input  logic [afc_pkg::COORD_W-1:0]   s_max_z,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [afc_pkg::TAG_W-1:0]     m_tag_out,
    output logic                          m_visible,
    output logic                          m_fully_inside,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int D = afc_pkg::PIPE_DEPTH;

    afc_pkg::plane_t               plane_reg [afc_pkg::NUM_PLANES];
    logic [afc_pkg::MARGIN_W-1:0]  margin_reg;

    logic [D-1:0]                  vld_reg;
    logic [D:0]                    rdy;
    logic [D-1:0]                  load;
    logic [afc_pkg::TAG_W-1:0]     tag_reg [D];

    afc_pkg::vec_t                 cen, ext;
    afc_pkg::plane_ctl_t           plane_ctl;
    afc_pkg::dist_t                pdist [afc_pkg::NUM_PLANES];
    afc_pkg::dist_t                rad   [afc_pkg::NUM_PLANES];

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
                plane_reg[i] <= '0;
            end
            margin_reg <= afc_pkg::MARGIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index) inside
                afc_pkg::REG_PLANE_LEFT, afc_pkg::REG_PLANE_RIGHT,
                afc_pkg::REG_PLANE_BOTTOM, afc_pkg::REG_PLANE_TOP,
                afc_pkg::REG_PLANE_NEAR, afc_pkg::REG_PLANE_FAR: begin
                    plane_reg[cfg_index] <= cfg_data;
                end
                afc_pkg::REG_CULL_MARGIN: begin
                    margin_reg <= cfg_data[afc_pkg::MARGIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ready chain: a stage takes a new item when empty or when it drains
    always_comb begin
        rdy[D] = m_ready;
        for (int k = D - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        load[0] = rdy[0] && s_valid;
        for (int k = 1; k < D; k++) begin
            load[k] = rdy[k] && vld_reg[k-1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < D; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // tag line alongside the arithmetic
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            tag_reg[0] <= s_object_tag;
        end
        for (int k = 1; k < D; k++) begin
            if (load[k]) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    afc_prep u_prep (
        .aclk  (aclk),
        .load  (load[afc_pkg::ST_PREP]),
        .min_x (s_min_x),
        .min_y (s_min_y),
        .min_z (s_min_z),
        .max_x (s_max_x),
        .max_y (s_max_y),
        .max_z (s_max_z),
        .cen   (cen),
        .ext   (ext)
    );

    assign plane_ctl.load_prod = load[afc_pkg::ST_PROD];
    assign plane_ctl.load_sum  = load[afc_pkg::ST_SUM];

    // one unit per plane
    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_plane
        afc_plane u_plane (
            .aclk  (aclk),
            .ctl   (plane_ctl),
            .plane (plane_reg[p]),
            .cen   (cen),
            .ext   (ext),
            .pdist (pdist[p]),
            .rad   (rad[p])
        );
    end

    afc_decide u_decide (
        .aclk         (aclk),
        .load         (load[afc_pkg::ST_OUT]),
        .pdist        (pdist),
        .rad          (rad),
        .margin       (margin_reg),
        .visible      (m_visible),
        .fully_inside (m_fully_inside)
    );

    assign s_ready   = rdy[0];
    assign m_valid   = vld_reg[D-1];
    assign m_tag_out = tag_reg[D-1];

endmodule

### sv/afc_checker.sv
// afc_checker: port-level assertions for aabb_frustum_classify, bound to the top
// depends on afc_pkg and aabb_frustum_classify

module afc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [afc_pkg::TAG_W-1:0]      m_tag_out,
    input logic                           m_visible,
    input logic                           m_fully_inside
);

    logic [afc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      s_fire, m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // boxes in flight
    always_comb begin
        cnt_next = cnt_reg;
        if (s_fire && !m_fire) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tag_out) && $stable(m_visible)
            && $stable(m_fully_inside))
        else $error("result changed while stalled");

    // no result without a box in flight, never more than the pipeline holds
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || cnt_reg != '0) && (cnt_reg <= afc_pkg::CNT_W'(afc_pkg::PIPE_DEPTH)))
        else $error("in-flight count out of range");

    // an accepting sink never blocks the source
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // fixed latency with no back-pressure
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing after pipeline latency");

endmodule

bind aabb_frustum_classify afc_checker u_afc_checker (.*);

### test/aabb_frustum_classify_test.sv
`timescale 1ns / 1ps
// aabb_frustum_classify_test: self-checking bench for the box/frustum classifier
// depends on afc_pkg and aabb_frustum_classify; a clocked driver and monitor
// compare every result with a local plane-test predictor

module aabb_frustum_classify_test;
    import afc_pkg::*;

    localparam int LONG_HOLD   = 300;   // cycles the receiver refuses results once
    localparam int STALL_LIMIT = 4000;  // cycles with no transaction before giving up
    localparam int ONE_Q14     = 16384;
    localparam int RANDOM_BOXES_PER_PHASE = 450;

    // index past the register list; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [TAG_W-1:0]              tag;
        logic [2:0][COORD_W-1:0]       lo;    // x, y, z minimum corner
        logic [2:0][COORD_W-1:0]       hi;    // x, y, z maximum corner
    } box_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             visible;
        logic             contained;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [TAG_W-1:0]       s_object_tag;
    logic [COORD_W-1:0]     s_min_x, s_min_y, s_min_z;
    logic [COORD_W-1:0]     s_max_x, s_max_y, s_max_z;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [TAG_W-1:0]       m_tag_out;
    logic                   m_visible;
    logic                   m_fully_inside;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow of the block's registers
    plane_t                 planes_model [NUM_PLANES];
    logic [MARGIN_W-1:0]    margin_model;

    box_t                   boxes_to_send [$];
    verdict_t               verdicts_due [$];
    box_t                   box_on_bus = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int long_holds_req = 0;
    int long_holds_done = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int boxes_checked = 0;
    int seen_visible = 0;
    int seen_inside = 0;
    int cfg_writes = 0;

    aabb_frustum_classify i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_object_tag   (s_object_tag),
        .s_min_x        (s_min_x),
        .s_min_y        (s_min_y),
        .s_min_z        (s_min_z),
        .s_max_x        (s_max_x),
        .s_max_y        (s_max_y),
        .s_max_z        (s_max_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tag_out      (m_tag_out),
        .m_visible      (m_visible),
        .m_fully_inside (m_fully_inside),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    assign s_object_tag = box_on_bus.tag;
    assign s_min_x      = box_on_bus.lo[0];
    assign s_min_y      = box_on_bus.lo[1];
    assign s_min_z      = box_on_bus.lo[2];
    assign s_max_x      = box_on_bus.hi[0];
    assign s_max_y      = box_on_bus.hi[1];
    assign s_max_z      = box_on_bus.hi[2];

    initial begin
        forever #6 aclk = ~aclk;
    end

    // visibility and containment of one box against the shadow planes
    function automatic verdict_t classify_box(input box_t b);
        longint lo_c, hi_c, coef, dist2, rad2, dist18, rad, margin;
        longint twice_ctr [3];
        longint span [3];
        verdict_t v;
        margin = margin_model;
        for (int k = 0; k < 3; k++) begin
            lo_c = $signed(b.lo[k]);
            hi_c = $signed(b.hi[k]);
            twice_ctr[k] = lo_c + hi_c;
            span[k] = hi_c - lo_c;   // negative on an inverted axis, kept as is
        end
        v.tag = b.tag;
        v.visible = 1'b1;
        v.contained = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            coef = $signed(planes_model[p][3*COEF_W +: COEF_W]);
            dist2 = coef * (longint'(1) << D_SHIFT);
            rad2 = 0;
            for (int k = 0; k < 3; k++) begin
                coef = $signed(planes_model[p][k*COEF_W +: COEF_W]);
                dist2 += coef * twice_ctr[k];
                rad2 += ((coef < 0) ? -coef : coef) * span[k];
            end
            // floor from 19 to 18 fraction bits
            dist18 = dist2 >>> 1;
            rad = rad2 >>> 1;
            if (dist18 + rad < -margin)
                v.visible = 1'b0;
            if (dist18 - rad < margin)
                v.contained = 1'b0;
        end
        return v;
    endfunction

    function automatic plane_t pack_plane(input int a, input int b, input int c, input int d);
        return {COEF_W'(d), COEF_W'(c), COEF_W'(b), COEF_W'(a)};
    endfunction

    // mostly boxes near the frustum, some inverted, some raw bit patterns
    function automatic box_t random_box();
        box_t b;
        int   shape, ctr, half;
        shape = $urandom_range(99);
        b.tag = TAG_W'($urandom);
        for (int k = 0; k < 3; k++) begin
            ctr = int'($urandom_range(7200)) - 3600;
            half = int'($urandom_range(1200));
            if (shape < 65) begin
                b.lo[k] = COORD_W'(ctr - half);
                b.hi[k] = COORD_W'(ctr + half);
            end else if (shape < 80) begin
                b.lo[k] = COORD_W'(ctr + half);
                b.hi[k] = COORD_W'(ctr - half);
            end else begin
                b.lo[k] = COORD_W'($urandom);
                b.hi[k] = COORD_W'($urandom);
            end
        end
        return b;
    endfunction

    task automatic push_box(input int tag, input int lx, input int ly, input int lz,
                            input int hx, input int hy, input int hz);
        box_t b;
        b.tag = TAG_W'(tag);
        b.lo = {COORD_W'(lz), COORD_W'(ly), COORD_W'(lx)};
        b.hi = {COORD_W'(hz), COORD_W'(hy), COORD_W'(hx)};
        boxes_to_send.insert(boxes_to_send.size(), b);
    endtask

    task automatic push_random(input int count);
        repeat (count) boxes_to_send.insert(boxes_to_send.size(), random_box());
    endtask

    // one register write transaction; the shadow follows at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input plane_t data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_PLANES)
            planes_model[idx] = data;
        else if (idx == REG_CULL_MARGIN)
            margin_model = data[MARGIN_W-1:0];
        cfg_writes++;
        @(negedge aclk);
    endtask

    // axis-aligned cube of half width half_q4 around the origin
    task automatic set_box_frustum(input int half_q4, input int margin);
        write_reg(REG_PLANE_LEFT,   pack_plane(ONE_Q14, 0, 0, half_q4));
        write_reg(REG_PLANE_RIGHT,  pack_plane(-ONE_Q14, 0, 0, half_q4));
        write_reg(REG_PLANE_BOTTOM, pack_plane(0, ONE_Q14, 0, half_q4));
        write_reg(REG_PLANE_TOP,    pack_plane(0, -ONE_Q14, 0, half_q4));
        write_reg(REG_PLANE_NEAR,   pack_plane(0, 0, ONE_Q14, half_q4));
        write_reg(REG_PLANE_FAR,    pack_plane(0, 0, -ONE_Q14, half_q4));
        write_reg(REG_CULL_MARGIN,  plane_t'(margin));
    endtask

    // sender stops until every expected result is back
    task automatic wait_drained();
        do @(negedge aclk); while (boxes_to_send.size() != 0 || s_valid
                                   || verdicts_due.size() != 0);
    endtask

    // box driver: next box goes on the bus once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                verdicts_due.insert(verdicts_due.size(), classify_box(box_on_bus));
            if (boxes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                box_on_bus <= boxes_to_send.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: tag %h visible %b inside %b",
                                 m_tag_out, m_visible, m_fully_inside);
                end else begin
                    want = verdicts_due.pop_front();
                    boxes_checked++;
                    seen_visible += want.visible;
                    seen_inside += want.contained;
                    if (m_tag_out !== want.tag || m_visible !== want.visible
                        || m_fully_inside !== want.contained) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: tag %h/%h visible %b/%b inside %b/%b",
                                     want.tag, m_tag_out, want.visible, m_visible,
                                     want.contained, m_fully_inside);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (long_holds_done != long_holds_req) begin
                hold_left <= LONG_HOLD;
                long_holds_done++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int p = 0; p < NUM_PLANES; p++)
            planes_model[p] = '0;
        margin_model = MARGIN_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset registers: zero planes, default margin
        push_box(16'h0000, 0, 0, 0, 0, 0, 0);
        push_box(16'h1234, -32768, -32768, -32768, 32767, 32767, 32767);
        push_box(16'hFFFF, 32767, 100, -5, -32768, -100, 5);
        wait_drained();

        // zero planes with zero margin report the box fully inside
        write_reg(REG_CULL_MARGIN, '0);
        push_box(16'h0101, 0, 0, 0, 0, 0, 0);
        push_box(16'h0202, -500, 40, 7, 900, 41, 8);
        wait_drained();

        // directed boxes against a cube of half width 100 units
        set_box_frustum(1600, MARGIN_RESET);
        push_box(16'h0001, -160, -160, -160, 160, 160, 160);
        push_box(16'h0002, -3200, -100, -100, -1700, 100, 100);
        push_box(16'h0003, 1700, -100, -100, 3200, 100, 100);
        push_box(16'h0004, -100, -3200, -100, 100, -1700, 100);
        push_box(16'h0005, -100, 1700, -100, 100, 3200, 100);
        push_box(16'h0006, -100, -100, -3200, 100, 100, -1700);
        push_box(16'h0007, -100, -100, 1700, 100, 100, 3200);
        push_box(16'h0008, -1800, -100, -100, -1400, 100, 100);
        // touching the left plane, then one step beyond it
        push_box(16'h0009, -2000, -100, -100, -1600, 100, 100);
        push_box(16'h000A, -2000, -100, -100, -1601, 100, 100);
        push_box(16'h000B, -32768, -32768, -32768, 32767, 32767, 32767);
        // inverted on every axis: negative radius
        push_box(16'h000C, 32767, 32767, 32767, -32768, -32768, -32768);
        push_box(16'h0000, 0, 0, 0, 0, 0, 0);
        push_box(16'hFFFF, 32767, 32767, 32767, 32767, 32767, 32767);
        push_box(16'h8000, -32768, -32768, -32768, -32768, -32768, -32768);
        wait_drained();

        // no idling, then one long receiver hold while the sender keeps going
        push_random(RANDOM_BOXES_PER_PHASE);
        long_holds_req++;
        wait_drained();

        // skewed planes, random margin, sender idling; pause halfway
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(REG_PLANE_LEFT + CFG_IDX_W'(p),
                      pack_plane(int'($urandom_range(32768)) - ONE_Q14,
                                 int'($urandom_range(32768)) - ONE_Q14,
                                 int'($urandom_range(32768)) - ONE_Q14,
                                 int'($urandom_range(6400)) - 3200));
        write_reg(REG_CULL_MARGIN, plane_t'($urandom_range(65535)));
        write_reg(REG_UNUSED, '1);
        send_idle_pct = 60;
        push_random(RANDOM_BOXES_PER_PHASE / 2);
        wait_drained();
        push_random(RANDOM_BOXES_PER_PHASE - RANDOM_BOXES_PER_PHASE / 2);
        wait_drained();

        // extreme coefficients and maximum margin, receiver stalling
        write_reg(REG_PLANE_LEFT,   pack_plane(32767, 32767, 32767, 32767));
        write_reg(REG_PLANE_RIGHT,  pack_plane(-32768, -32768, -32768, -32768));
        write_reg(REG_PLANE_BOTTOM, '1);
        write_reg(REG_PLANE_TOP,    {$urandom, $urandom});
        write_reg(REG_PLANE_NEAR,   '0);
        write_reg(REG_PLANE_FAR,    {$urandom, $urandom});
        write_reg(REG_CULL_MARGIN,  plane_t'(16'hFFFF));
        write_reg(REG_UNUSED, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_stall_pct = 60;
        push_random(RANDOM_BOXES_PER_PHASE);
        wait_drained();

        // smaller cube, zero margin, both sides idling
        set_box_frustum(800, 0);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        push_random(RANDOM_BOXES_PER_PHASE);
        wait_drained();

        // let any stray result show up
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
        if (verdicts_due.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", verdicts_due.size());
        end

        $display("checked %0d boxes after %0d register writes: %0d visible, %0d fully inside",
                 boxes_checked, cfg_writes, seen_visible, seen_inside);
        $display("idle mixes: none, sender 60%%, receiver 60%%, both 22%%, one long hold");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
